[sv/tea_pkg.sv]
// Shared types, constants and helpers for the TEA block cipher.
// No dependencies; every other file refers to this package by scoped names.
package tea_pkg;

    localparam int unsigned ROUNDS = 32;
    localparam int unsigned STAGES = 2 * ROUNDS;
    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    localparam logic [WORD_W-1:0] KEY0_RST = 32'h8720_458F;
    localparam logic [WORD_W-1:0] KEY1_RST = 32'hA8B6_C0DE;
    localparam logic [WORD_W-1:0] KEY2_RST = 32'h3F1E_9A40;
    localparam logic [WORD_W-1:0] KEY3_RST = 32'hA9B7_83FE;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        KEY_WORD_0 = 2'd0,
        KEY_WORD_1 = 2'd1,
        KEY_WORD_2 = 2'd2,
        KEY_WORD_3 = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } key_t;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
    } item_t;

    // delta * n, mod 2^32
    function automatic logic [WORD_W-1:0] round_sum(input logic [WORD_W-1:0] n);
        logic [2*WORD_W-1:0] prod;
        prod = {{WORD_W{1'b0}}, DELTA} * {{WORD_W{1'b0}}, n};
        return prod[WORD_W-1:0];
    endfunction

endpackage

[sv/tea_in_if.sv]
// Input block channel: valid/ready plus mode and the two block words.
// Depends on tea_pkg for the word width.
interface tea_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [tea_pkg::WORD_W-1:0]    first_word;
    logic [tea_pkg::WORD_W-1:0]    second_word;

    modport source (output valid, output mode, output first_word, output second_word,
                    input ready);
    modport sink   (input valid, input mode, input first_word, input second_word,
                    output ready);
endinterface

[sv/tea_out_if.sv]
// Result block channel: valid/ready plus the two result words.
// Depends on tea_pkg for the word width.
interface tea_out_if;
    logic                          valid;
    logic                          ready;
    logic [tea_pkg::WORD_W-1:0]    first_out;
    logic [tea_pkg::WORD_W-1:0]    second_out;

    modport source (output valid, output first_out, output second_out, input ready);
    modport sink   (input valid, input first_out, input second_out, output ready);
endinterface

[sv/tea_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on tea_pkg for index and word widths.
interface tea_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tea_pkg::CFG_IDX_W-1:0] index;
    logic [tea_pkg::WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/tea_key_regs.sv]
// Key register file: four 32-bit key words written through the config channel.
// Depends on tea_pkg and tea_cfg_if.
module tea_key_regs (
    input  logic           clk,
    input  logic           rst_n,
    tea_cfg_if.sink        cfg,
    output tea_pkg::key_t  key
);

    tea_pkg::key_t key_reg;
    tea_pkg::key_t key_next;

    assign cfg.ready = 1'b1;
    assign key       = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (cfg.valid)
        begin
            unique case (tea_pkg::cfg_idx_t'(cfg.index))
                tea_pkg::KEY_WORD_0: key_next.k0 = cfg.data;
                tea_pkg::KEY_WORD_1: key_next.k1 = cfg.data;
                tea_pkg::KEY_WORD_2: key_next.k2 = cfg.data;
                tea_pkg::KEY_WORD_3: key_next.k3 = cfg.data;
                default:             key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg.k0 <= tea_pkg::KEY0_RST;
            key_reg.k1 <= tea_pkg::KEY1_RST;
            key_reg.k2 <= tea_pkg::KEY2_RST;
            key_reg.k3 <= tea_pkg::KEY3_RST;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

endmodule

[sv/tea_half_round.sv]
// One registered half-round: updates one block word with the TEA mix function.
// Depends on tea_pkg; stage constants (round sums, parity) come in as ports.
module tea_half_round (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       odd,
    input  logic [tea_pkg::WORD_W-1:0] sum_enc,
    input  logic [tea_pkg::WORD_W-1:0] sum_dec,
    input  tea_pkg::key_t              key,
    input  logic                       in_vld,
    input  tea_pkg::item_t             in_item,
    output logic                       out_vld,
    output tea_pkg::item_t             out_item
);

    logic                       vld_reg;
    tea_pkg::item_t             item_reg;
    tea_pkg::item_t             item_next;
    logic                       upd_y;
    logic [tea_pkg::WORD_W-1:0] w;
    logic [tea_pkg::WORD_W-1:0] kl;
    logic [tea_pkg::WORD_W-1:0] kr;
    logic [tea_pkg::WORD_W-1:0] sum;
    logic [tea_pkg::WORD_W-1:0] mix;
    logic [tea_pkg::WORD_W-1:0] tgt;
    logic [tea_pkg::WORD_W-1:0] tgt_new;

    // encrypt: y then z; decrypt: z then y
    assign upd_y = (odd == in_item.mode);
    assign w     = upd_y ? in_item.z : in_item.y;
    assign kl    = upd_y ? key.k0 : key.k2;
    assign kr    = upd_y ? key.k1 : key.k3;
    assign sum   = in_item.mode ? sum_dec : sum_enc;
    assign mix   = ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
    assign tgt   = upd_y ? in_item.y : in_item.z;
    assign tgt_new = in_item.mode ? (tgt - mix) : (tgt + mix);

    always_comb
    begin
        item_next = in_item;
        if (upd_y)
        begin
            item_next.y = tgt_new;
        end
        else
        begin
            item_next.z = tgt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

[sv/tea_block_cipher.sv]
// Top level of the TEA block cipher: key registers and the half-round pipeline.
// Depends on tea_pkg, tea_in_if, tea_out_if, tea_cfg_if, tea_key_regs, tea_half_round.

// TEA (32 rounds) encrypt/decrypt of one 64-bit block per transfer. The datapath is
// a pipeline of 64 registered half-round stages, one word update per stage, so a
// block is accepted every cycle while the pipeline is not held, and its result
// emerges from the last stage. The whole pipeline, output register included, advances
// together and holds while a result waits on a low result ready. Key words reset to the
// built-in key; write them only while no block is in flight.
module tea_block_cipher (
    input  logic       clk,
    input  logic       rst_n,
    tea_in_if.sink     block,
    tea_out_if.source  result,
    tea_cfg_if.sink    cfg
);

    tea_pkg::key_t  key;
    logic           en;
    logic           vld  [tea_pkg::STAGES+1];
    tea_pkg::item_t item [tea_pkg::STAGES+1];

    tea_key_regs u_keys (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .key   (key)
    );

    assign en          = !vld[tea_pkg::STAGES] || result.ready;
    assign block.ready = en;

    assign vld[0]       = block.valid;
    assign item[0].mode = block.mode;
    assign item[0].y    = block.first_word;
    assign item[0].z    = block.second_word;

    for (genvar s = 0; s < tea_pkg::STAGES; s++)
    begin : g_stage
        tea_half_round u_hr (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .odd      (1'(s % 2)),
            .sum_enc  (tea_pkg::round_sum(32'(s / 2 + 1))),
            .sum_dec  (tea_pkg::round_sum(32'(tea_pkg::ROUNDS - s / 2))),
            .key      (key),
            .in_vld   (vld[s]),
            .in_item  (item[s]),
            .out_vld  (vld[s+1]),
            .out_item (item[s+1])
        );
    end

    assign result.valid      = vld[tea_pkg::STAGES];
    assign result.first_out  = item[tea_pkg::STAGES].y;
    assign result.second_out = item[tea_pkg::STAGES].z;

`ifndef SYNTHESIS
    a_stall_holds_first: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld[1]))
        else $error("first stage valid changed during stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        block.valid && block.ready |=> vld[1])
        else $error("accepted block did not enter the pipeline");

    a_key0_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && (cfg.index == tea_pkg::KEY_WORD_0)
        |=> key.k0 == $past(cfg.data))
        else $error("key word 0 write not applied");
`endif

endmodule

[dv/tb.sv]
// Testbench for tea_block_cipher: random and corner-case blocks in both modes under
// several keys, with results checked in order against a built-in TEA predictor.
// Depends on tea_pkg and the tea_in_if, tea_out_if and tea_cfg_if interfaces.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [tea_pkg::WORD_W-1:0] word_t;

    typedef struct packed {
        word_t first;
        word_t second;
    } block_out_t;

    typedef struct packed {
        tea_pkg::cfg_idx_t idx;
        word_t             data;
    } key_write_t;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = tea_pkg::STAGES + 8;
    localparam int MAX_SHOWN    = 10;

    logic clk;
    logic rst_n;

    tea_in_if  blk_if();
    tea_out_if res_if();
    tea_cfg_if cfg_if();

    tea_block_cipher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .block  (blk_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    tea_pkg::item_t block_q[$];
    block_out_t     predicted_q[$];
    key_write_t     key_write_q[$];
    tea_pkg::key_t  key_now;

    int   mismatches = 0;
    int   send_gap   = 0;
    int   stall_left = 0;
    int   hold_left  = 0;
    logic in_calm;
    logic out_calm;
    logic hold_req;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic word_t tea_mix(word_t w, word_t s, word_t kl, word_t kr);
        return ((w << 4) + kl) ^ (w + s) ^ ((w >> 5) + kr);
    endfunction

    function automatic block_out_t tea_transform(tea_pkg::item_t blk, tea_pkg::key_t k);
        word_t y;
        word_t z;
        word_t sum;
        y = blk.y;
        z = blk.z;
        if (blk.mode == MODE_ENC)
        begin
            sum = '0;
            for (int r = 0; r < tea_pkg::ROUNDS; r++)
            begin
                sum += tea_pkg::DELTA;
                y += tea_mix(z, sum, k.k0, k.k1);
                z += tea_mix(y, sum, k.k2, k.k3);
            end
        end
        else
        begin
            sum = tea_pkg::DELTA * word_t'(tea_pkg::ROUNDS);
            for (int r = 0; r < tea_pkg::ROUNDS; r++)
            begin
                z -= tea_mix(y, sum, k.k2, k.k3);
                y -= tea_mix(z, sum, k.k0, k.k1);
                sum -= tea_pkg::DELTA;
            end
        end
        return {y, z};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(0, 31);
            3: return ~(word_t'(1) << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin : drive_blocks
        tea_pkg::item_t taken;
        tea_pkg::item_t nxt;
        logic           next_valid;
        if (rst_n)
        begin
            next_valid = blk_if.valid;
            if (blk_if.valid && blk_if.ready)
            begin
                taken.mode = blk_if.mode;
                taken.y    = blk_if.first_word;
                taken.z    = blk_if.second_word;
                predicted_q.push_back(tea_transform(taken, key_now));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (block_q.size() > 0)
                begin
                    nxt = block_q.pop_front();
                    blk_if.mode        <= nxt.mode;
                    blk_if.first_word  <= nxt.y;
                    blk_if.second_word <= nxt.z;
                    next_valid = 1'b1;
                    send_gap = in_calm ? 0 : pick_gap();
                end
            end
            blk_if.valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin : check_results
        block_out_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (predicted_q.size() == 0)
                begin
                    if (mismatches < MAX_SHOWN)
                        $display("unexpected result: first %h second %h",
                                 res_if.first_out, res_if.second_out);
                    mismatches++;
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (res_if.first_out !== want.first || res_if.second_out !== want.second)
                    begin
                        if (mismatches < MAX_SHOWN)
                            $display("mismatch: first exp %h got %h, second exp %h got %h",
                                     want.first, res_if.first_out,
                                     want.second, res_if.second_out);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
                res_if.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                stall_left = out_calm ? 0 : pick_gap();
            end
        end
    end

    // long receiver hold-off so the pipeline fills and backs up the input
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin : write_keys
        key_write_t kw;
        logic       next_valid;
        if (rst_n)
        begin
            next_valid = cfg_if.valid;
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.index)
                    tea_pkg::KEY_WORD_0: key_now.k0 = cfg_if.data;
                    tea_pkg::KEY_WORD_1: key_now.k1 = cfg_if.data;
                    tea_pkg::KEY_WORD_2: key_now.k2 = cfg_if.data;
                    tea_pkg::KEY_WORD_3: key_now.k3 = cfg_if.data;
                    default: ;
                endcase
                next_valid = 1'b0;
            end
            if (!next_valid && key_write_q.size() > 0)
            begin
                kw = key_write_q.pop_front();
                cfg_if.index <= kw.idx;
                cfg_if.data  <= kw.data;
                next_valid = 1'b1;
            end
            cfg_if.valid <= next_valid;
        end
    end

    task automatic wait_idle();
        while (block_q.size() > 0 || blk_if.valid || predicted_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic set_key(input tea_pkg::key_t k);
        key_write_q.push_back({tea_pkg::KEY_WORD_0, k.k0});
        key_write_q.push_back({tea_pkg::KEY_WORD_1, k.k1});
        key_write_q.push_back({tea_pkg::KEY_WORD_2, k.k2});
        key_write_q.push_back({tea_pkg::KEY_WORD_3, k.k3});
        while (key_write_q.size() > 0 || cfg_if.valid)
            @(posedge clk);
    endtask

    task automatic queue_block(input logic md, input word_t y, input word_t z);
        tea_pkg::item_t blk;
        blk.mode = md;
        blk.y    = y;
        blk.z    = z;
        block_q.push_back(blk);
    endtask

    // random blocks, many followed by the inverse operation on their own result
    task automatic queue_random(input int n);
        tea_pkg::item_t blk;
        block_out_t     res;
        int             made;
        made = 0;
        while (made < n)
        begin
            blk.mode = 1'($urandom_range(0, 1));
            blk.y    = rand_word();
            blk.z    = rand_word();
            block_q.push_back(blk);
            made++;
            if ($urandom_range(0, 99) < 45)
            begin
                res = tea_transform(blk, key_now);
                queue_block(~blk.mode, res.first, res.second);
                made++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic md;
        rst_n              = 1'b0;
        blk_if.valid       = 1'b0;
        blk_if.mode        = MODE_ENC;
        blk_if.first_word  = '0;
        blk_if.second_word = '0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = tea_pkg::KEY_WORD_0;
        cfg_if.data        = '0;
        in_calm            = 1'b0;
        out_calm           = 1'b0;
        hold_req           = 1'b0;
        key_now            = {tea_pkg::KEY0_RST, tea_pkg::KEY1_RST,
                              tea_pkg::KEY2_RST, tea_pkg::KEY3_RST};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner blocks under the reset key
        for (int m = 0; m < 2; m++)
        begin
            md = m ? MODE_DEC : MODE_ENC;
            queue_block(md, 32'h0000_0000, 32'h0000_0000);
            queue_block(md, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            queue_block(md, 32'h0000_0000, 32'hFFFF_FFFF);
            queue_block(md, 32'hFFFF_FFFF, 32'h0000_0000);
            queue_block(md, 32'hAAAA_AAAA, 32'h5555_5555);
            queue_block(md, 32'h5555_5555, 32'hAAAA_AAAA);
            queue_block(md, 32'h8000_0000, 32'h0000_0001);
            queue_block(md, 32'h0000_0001, 32'h8000_0000);
        end
        queue_random(230);
        wait_idle();

        set_key('0);
        in_calm  <= 1'b1;
        out_calm <= 1'b0;
        queue_random(200);
        wait_idle();

        set_key('1);
        in_calm  <= 1'b0;
        out_calm <= 1'b1;
        queue_random(200);
        wait_idle();

        set_key({$urandom, $urandom, $urandom, $urandom});
        in_calm  <= 1'b1;
        out_calm <= 1'b0;
        queue_random(300);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        wait_idle();

        set_key({rand_word(), rand_word(), rand_word(), rand_word()});
        in_calm  <= 1'b0;
        out_calm <= 1'b0;
        queue_random(250);
        wait_idle();

        set_key({tea_pkg::KEY0_RST, tea_pkg::KEY1_RST, tea_pkg::KEY2_RST, tea_pkg::KEY3_RST});
        in_calm  <= 1'b1;
        out_calm <= 1'b1;
        queue_random(230);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && predicted_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #10_800_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
